// ----- rtl/slxfr_pkg.sv -----
// Shared types, constants and helpers for the sync/length/XOR frame receiver.
`timescale 1ns / 1ps

package slxfr_pkg;

    localparam int MAX_FRAME_LEN = 13;
    localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);
    localparam int ADDR_W        = $clog2(MAX_FRAME_LEN);

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OUT_TDATA_W = 40;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    localparam kind_t KIND_RESP_EVENT = 4'd0;
    localparam kind_t KIND_BCAST      = 4'd1;
    localparam kind_t KIND_ACK        = 4'd2;
    localparam kind_t KIND_BURST      = 4'd3;
    localparam kind_t KIND_EXT_BCAST  = 4'd4;
    localparam kind_t KIND_EXT_ACK    = 4'd5;
    localparam kind_t KIND_EXT_BURST  = 4'd6;
    localparam kind_t KIND_OTHER_RESP = 4'd7;
    localparam kind_t KIND_ERROR      = 4'd8;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BAD_XOR  = 2'd1;
    localparam status_t ST_TOO_LONG = 2'd2;

    localparam byte_t ID_RESP_EVENT = 8'h40;
    localparam byte_t ID_BCAST      = 8'h4E;
    localparam byte_t ID_ACK        = 8'h4F;
    localparam byte_t ID_BURST      = 8'h50;
    localparam byte_t ID_EXT_BCAST  = 8'h5D;
    localparam byte_t ID_EXT_ACK    = 8'h5E;
    localparam byte_t ID_EXT_BURST  = 8'h5F;

    localparam logic CFG_SYNC_BYTE   = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_ID      = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CHECK   = 7'b0010000,
        PH_ISSUE   = 7'b0100000,
        PH_RDATA   = 7'b1000000
    } phase_t;

    // 0 means "not a data id"
    function automatic kind_t data_kind(input byte_t id);
        kind_t k;
        case (id)
            ID_BCAST:     k = KIND_BCAST;
            ID_ACK:       k = KIND_ACK;
            ID_BURST:     k = KIND_BURST;
            ID_EXT_BCAST: k = KIND_EXT_BCAST;
            ID_EXT_ACK:   k = KIND_EXT_ACK;
            ID_EXT_BURST: k = KIND_EXT_BURST;
            default:      k = KIND_RESP_EVENT;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/sync_length_xor_frame_receiver_unit.sv -----
// Frame receiver: sync hunt, length/id/payload/checksum parse, payload drain.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-------------------------------------
//   s_ (rx)   | in  | s_tvalid/s_tready  | s_tdata: rx_byte
//   m_ (res)  | out | m_tvalid/m_tready  | m_tdata, m_tuser: kind, m_tlast: last
//   cfg       | in  | cfg_wr_en          | cfg_addr, cfg_wdata
//
// Header and payload bytes are taken one per cycle. The checksum byte is taken
// once the output register is free; an error frame or a channel-only data frame
// yields its single result right then. Other frames drain from the payload RAM
// (RAM read, then output load per result), input held off until the last result.
// Synchronous active-low reset returns to sync hunt; RAM contents are not reset.
`timescale 1ns / 1ps

module sync_length_xor_frame_receiver_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  slxfr_pkg::byte_t               s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [9:2] msg_id, [17:10] channel, [25:18] code,
    // [33:26] payload_byte, [37:34] byte_index, [39:38] zero
    output logic [slxfr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output slxfr_pkg::kind_t               m_tuser,   // [3:0] kind
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  slxfr_pkg::byte_t               cfg_wdata
);
    import slxfr_pkg::*;

    // configuration
    byte_t sync_byte_reg;
    len_t  max_payload_reg;

    // parse state
    phase_t phase_reg, phase_next;
    len_t   frame_len_reg, frame_len_next;
    len_t   taken_reg, taken_next;
    byte_t  xor_reg, xor_next;
    byte_t  msg_id_reg, msg_id_next;
    byte_t  channel_reg, channel_next;
    byte_t  third_reg, third_next;

    // drain state
    addr_t  rd_addr_reg, rd_addr_next;
    len_t   idx_reg, idx_next;
    kind_t  fkind_reg, fkind_next;
    byte_t  fcode_reg, fcode_next;

    // payload RAM
    byte_t  mem [MAX_FRAME_LEN];
    byte_t  rd_data_reg;
    logic   mem_we;
    logic   mem_re;

    // output register
    logic    out_valid_reg, out_valid_next;
    kind_t   o_kind_reg, o_kind_next;
    status_t o_status_reg, o_status_next;
    byte_t   o_code_reg, o_code_next;
    byte_t   o_byte_reg, o_byte_next;
    len_t    o_idx_reg, o_idx_next;
    logic    o_last_reg, o_last_next;
    byte_t   o_id_reg, o_id_next;
    byte_t   o_chan_reg, o_chan_next;

    logic  out_free;
    logic  in_acc;
    byte_t b;
    byte_t xor_fin;
    kind_t dk;
    logic  oversize;
    logic  rd_last;
    len_t  last_pos;

    assign out_free = !out_valid_reg || m_tready;
    assign b        = s_tdata;
    assign in_acc   = s_tvalid && s_tready;
    assign xor_fin  = xor_reg ^ b;
    assign dk       = data_kind(msg_id_reg);
    assign oversize = (msg_id_reg != ID_RESP_EVENT) && (frame_len_reg > max_payload_reg);
    assign last_pos = frame_len_reg - len_t'(1);
    assign rd_last  = (len_t'(rd_addr_reg) == last_pos);

    always_comb begin
        case (phase_reg)
            PH_HUNT, PH_LEN, PH_ID, PH_PAYLOAD: s_tready = 1'b1;
            PH_CHECK:                           s_tready = out_free;
            default:                            s_tready = 1'b0;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        taken_next     = taken_reg;
        xor_next       = xor_reg;
        msg_id_next    = msg_id_reg;
        channel_next   = channel_reg;
        third_next     = third_reg;
        rd_addr_next   = rd_addr_reg;
        idx_next       = idx_reg;
        fkind_next     = fkind_reg;
        fcode_next     = fcode_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        o_kind_next    = o_kind_reg;
        o_status_next  = o_status_reg;
        o_code_next    = o_code_reg;
        o_byte_next    = o_byte_reg;
        o_idx_next     = o_idx_reg;
        o_last_next    = o_last_reg;
        o_id_next      = o_id_reg;
        o_chan_next    = o_chan_reg;

        case (phase_reg)
            PH_HUNT: begin
                if (in_acc && b == sync_byte_reg) begin
                    xor_next   = b;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (in_acc) begin
                    if (b >= 8'd1 && b <= BYTE_W'(MAX_FRAME_LEN)) begin
                        frame_len_next = b[LEN_W-1:0];
                        xor_next       = xor_reg ^ b;
                        phase_next     = PH_ID;
                    end else if (b == sync_byte_reg) begin
                        // bad length byte may itself open a new frame
                        xor_next   = b;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_ID: begin
                if (in_acc) begin
                    msg_id_next = b;
                    xor_next    = xor_reg ^ b;
                    taken_next  = '0;
                    phase_next  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (in_acc) begin
                    mem_we   = 1'b1;
                    xor_next = xor_reg ^ b;
                    if (taken_reg == len_t'(0)) channel_next = b;
                    if (taken_reg == len_t'(2)) third_next = b;
                    taken_next = taken_reg + len_t'(1);
                    if (taken_next >= frame_len_reg) phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (in_acc) begin
                    xor_next    = xor_fin;
                    phase_next  = PH_HUNT;
                    o_id_next   = msg_id_reg;
                    o_chan_next = channel_reg;
                    o_byte_next = '0;
                    o_idx_next  = '0;
                    o_last_next = 1'b1;
                    if (xor_fin != 8'd0 || oversize) begin
                        out_valid_next = 1'b1;
                        o_kind_next    = KIND_ERROR;
                        o_status_next  = (xor_fin != 8'd0) ? ST_BAD_XOR : ST_TOO_LONG;
                        o_code_next    = '0;
                    end else if (dk != KIND_RESP_EVENT && frame_len_reg == len_t'(1)) begin
                        // data frame holding only the channel byte
                        out_valid_next = 1'b1;
                        o_kind_next    = dk;
                        o_status_next  = ST_OK;
                        o_code_next    = BYTE_W'(dk);
                    end else begin
                        idx_next   = '0;
                        phase_next = PH_ISSUE;
                        if (msg_id_reg == ID_RESP_EVENT) begin
                            fkind_next   = KIND_RESP_EVENT;
                            fcode_next   = (frame_len_reg >= len_t'(3)) ? third_reg : 8'd0;
                            rd_addr_next = addr_t'(0);
                        end else if (dk != KIND_RESP_EVENT) begin
                            fkind_next   = dk;
                            fcode_next   = BYTE_W'(dk);
                            rd_addr_next = addr_t'(1);
                        end else begin
                            fkind_next   = KIND_OTHER_RESP;
                            fcode_next   = msg_id_reg;
                            rd_addr_next = addr_t'(0);
                        end
                    end
                end
            end
            PH_ISSUE: begin
                mem_re     = 1'b1;
                phase_next = PH_RDATA;
            end
            PH_RDATA: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    o_kind_next    = fkind_reg;
                    o_status_next  = ST_OK;
                    o_code_next    = fcode_reg;
                    o_byte_next    = rd_data_reg;
                    o_idx_next     = idx_reg;
                    o_last_next    = rd_last;
                    o_id_next      = msg_id_reg;
                    o_chan_next    = channel_reg;
                    if (rd_last) begin
                        phase_next = PH_HUNT;
                    end else begin
                        rd_addr_next = rd_addr_reg + addr_t'(1);
                        idx_next     = idx_reg + len_t'(1);
                        phase_next   = PH_ISSUE;
                    end
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    // payload RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[taken_reg[ADDR_W-1:0]] <= b;
        if (mem_re) rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg   <= 8'd164;
            max_payload_reg <= 4'd9;
            phase_reg       <= PH_HUNT;
            frame_len_reg   <= '0;
            taken_reg       <= '0;
            xor_reg         <= '0;
            msg_id_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SYNC_BYTE:   sync_byte_reg   <= cfg_wdata;
                    CFG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[LEN_W-1:0];
                    default:         sync_byte_reg   <= sync_byte_reg;
                endcase
            end
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            taken_reg     <= taken_next;
            xor_reg       <= xor_next;
            msg_id_reg    <= msg_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        channel_reg  <= channel_next;
        third_reg    <= third_next;
        rd_addr_reg  <= rd_addr_next;
        idx_reg      <= idx_next;
        fkind_reg    <= fkind_next;
        fcode_reg    <= fcode_next;
        o_kind_reg   <= o_kind_next;
        o_status_reg <= o_status_next;
        o_code_reg   <= o_code_next;
        o_byte_reg   <= o_byte_next;
        o_idx_reg    <= o_idx_next;
        o_last_reg   <= o_last_next;
        o_id_reg     <= o_id_next;
        o_chan_reg   <= o_chan_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {2'b00, o_idx_reg, o_byte_reg, o_code_reg, o_chan_reg,
                       o_id_reg, o_status_reg};

    // error results are always single, final transactions
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("error result without last");

    a_err_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (o_status_reg != ST_OK)))
        else $error("kind and status disagree");

    a_no_rx_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ISSUE || phase_reg == PH_RDATA) |-> !s_tready)
        else $error("input taken during payload drain");

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ISSUE) |-> (len_t'(rd_addr_reg) < frame_len_reg))
        else $error("RAM read beyond frame length");

    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RDATA && out_free && rd_last) |=> (phase_reg == PH_HUNT && m_tlast))
        else $error("drain did not end on last result");

endmodule
